FILE: rtl/core/ghw_pkg.sv
// Shared types and constants for the per-glyph hue wave color block.
package ghw_pkg;

	localparam int PHASE_W = 17;
	localparam logic [16:0] PHASE_ONE = 17'h10000;

	// HSV scaling: channel = round(V * (DEN - S * x) / DEN), DEN = 255 * 65536
	localparam logic [23:0] HSV_DEN = 24'd16711680;
	localparam logic [31:0] HSV_HALF = 32'd8355840;
	// ceil(2^24 / 255), exact for quotients of 16-bit dividends
	localparam logic [16:0] RECIP_255 = 17'd65794;
	// ceil(2^24 / 10), exact for dividends below 2^22
	localparam logic [20:0] RECIP_10 = 21'd1677722;
	localparam logic [20:0] DT_ROUND = 21'd5;

	// Configuration register indexes
	localparam logic [1:0] CFG_GLYPH_COUNT = 2'd0;
	localparam logic [1:0] CFG_PHASE_SPACING = 2'd1;
	localparam logic [1:0] CFG_SATURATION = 2'd2;
	localparam logic [1:0] CFG_BRIGHTNESS = 2'd3;

	localparam logic FUNC_SEED = 1'b0;
	localparam logic FUNC_APPLY = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  glyph_index;
		logic [19:0] delta_time;
	} item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       index_error;
	} result_t;

	// Hue sectors of 60 degrees each
	typedef enum logic [2:0] {
		HUE_RY = 3'd0,
		HUE_YG = 3'd1,
		HUE_GC = 3'd2,
		HUE_CB = 3'd3,
		HUE_BM = 3'd4,
		HUE_MR = 3'd5
	} hue_sector_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MIX,
		ST_SCALE,
		ST_DIVIDE
	} ghw_state_t;

	// Control strobes from the sequencer
	typedef struct packed {
		logic busy;
		logic accept_ok;
		logic load_s2;
		logic phase_wr;
		logic result_ld;
	} ghw_ctrl_t;

endpackage

FILE: rtl/core/ghw_phase_ram.sv
// Per-glyph phase memory: one write port, one registered read port.
module ghw_phase_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [ghw_pkg::PHASE_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [ghw_pkg::PHASE_W-1:0]   rd_data
);

	logic [ghw_pkg::PHASE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/ghw_hsv_chan.sv
// One HSV channel lane: V * (1 - S/255 * x/65536), rounded half up, registered at diff_s3 and quot_s4.
module ghw_hsv_chan (
	input  logic        clk,
	input  logic [16:0] x,
	input  logic [7:0]  sat,
	input  logic [7:0]  val,
	output logic [7:0]  chan
);

	logic [24:0] sx;
	logic [23:0] diff_s3;
	logic [31:0] num;
	logic [15:0] quot_s4;
	logic [32:0] recip_prod;

	// S * x, at most 255 * 65536, so DEN - S * x never underflows
	assign sx = {17'b0, sat} * {8'b0, x};

	always_ff @(posedge clk) begin
		diff_s3 <= ghw_pkg::HSV_DEN - sx[23:0];
	end

	// V * diff + DEN/2 stays below 2^32; dividing by 65536 is a shift
	assign num = ({24'b0, val} * {8'b0, diff_s3}) + ghw_pkg::HSV_HALF;

	always_ff @(posedge clk) begin
		quot_s4 <= num[31:16];
	end

	// divide by 255 through the reciprocal
	assign recip_prod = {17'b0, quot_s4} * {16'b0, ghw_pkg::RECIP_255};
	assign chan = recip_prod[31:24];

endmodule

FILE: rtl/core/ghw_ctrl.sv
// Item sequencer: lookup, mix, scale and divide steps of one transaction.
module ghw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output ghw_pkg::ghw_ctrl_t  ctrl
);

	ghw_pkg::ghw_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghw_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ghw_pkg::ST_IDLE: begin
				if (start) state_nxt = ghw_pkg::ST_LOOKUP;
			end
			ghw_pkg::ST_LOOKUP: state_nxt = ghw_pkg::ST_MIX;
			ghw_pkg::ST_MIX:    state_nxt = ghw_pkg::ST_SCALE;
			ghw_pkg::ST_SCALE:  state_nxt = ghw_pkg::ST_DIVIDE;
			ghw_pkg::ST_DIVIDE: begin
				state_nxt = start ? ghw_pkg::ST_LOOKUP : ghw_pkg::ST_IDLE;
			end
			default: state_nxt = ghw_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		unique case (state_q)
			ghw_pkg::ST_IDLE: begin
				ctrl.accept_ok = 1'b1;
			end
			ghw_pkg::ST_LOOKUP: begin
				ctrl.busy = 1'b1;
				ctrl.load_s2 = 1'b1;
			end
			ghw_pkg::ST_MIX: begin
				ctrl.busy = 1'b1;
				ctrl.phase_wr = 1'b1;
			end
			ghw_pkg::ST_SCALE: begin
				ctrl.busy = 1'b1;
			end
			ghw_pkg::ST_DIVIDE: begin
				ctrl.accept_ok = 1'b1;
				ctrl.result_ld = 1'b1;
			end
			default: ctrl = '0;
		endcase
	end

endmodule

FILE: rtl/core/per_glyph_hue_wave_color.sv
// Top level of the per-glyph hue wave color block.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------
//  item     | start, busy (start & !busy) | item: func, glyph_index, delta_time
//  result   | done (one-cycle strobe)     | result: red, green, blue, index_error
//  config   | cfg_valid, cfg_ready        | cfg_index, cfg_data
//
// Each transaction passes the registered phase memory read, the lookup register,
// the HSV channel lane registers and the result register, and done is loaded at
// the same edge as the result. busy drops in the last step, so the next
// item is taken at the edge that loads the result. busy covers the phase
// read-modify-write, so two items on one glyph never overlap. Reset clears
// control state and loads register defaults; results cannot stall, config is always ready.
module per_glyph_hue_wave_color #(
	parameter int MAX_GLYPHS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ghw_pkg::item_t    item,
	output logic              done,
	output ghw_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;

	// configuration registers
	logic [8:0]  glyph_count_q;
	logic [15:0] phase_spacing_q;
	logic [7:0]  saturation_q;
	logic [7:0]  brightness_q;

	// item held for the whole transaction
	logic        func_q;
	logic        err_q;
	logic [7:0]  idx_q;
	logic [19:0] dt_q;

	ghw_pkg::ghw_ctrl_t ctrl;
	logic        accept;
	logic        err_in;
	logic [12:0] idx_wide;
	logic [12:0] idx_q_wide;

	logic [ghw_pkg::PHASE_W-1:0] rd_data;
	logic [ghw_pkg::PHASE_W-1:0] wr_data;

	// lookup step
	logic [16:0] ph_clamp;
	logic [18:0] h6;
	ghw_pkg::hue_sector_t sector;
	logic [20:0] dt_round;
	logic [41:0] inc_prod;
	logic [23:0] seed_prod;
	logic [16:0] seed;

	logic [16:0] ph_s2;
	logic [15:0] frac_s2;
	logic [16:0] inc_s2;
	logic [16:0] seed_s2;
	ghw_pkg::hue_sector_t sector_s2;

	// mix step
	logic [17:0] adv_sum;
	logic [16:0] adv_phase;
	logic [16:0] x_q_lane;
	logic [16:0] x_t_lane;

	logic [7:0] chan_p, chan_q, chan_t, chan_v;
	logic [7:0] red_c, green_c, blue_c;

	logic        done_q;
	ghw_pkg::result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= 9'd256;
			phase_spacing_q <= 16'd256;
			saturation_q <= 8'd255;
			brightness_q <= 8'd255;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ghw_pkg::CFG_GLYPH_COUNT:   glyph_count_q <= cfg_data[8:0];
				ghw_pkg::CFG_PHASE_SPACING: phase_spacing_q <= cfg_data;
				ghw_pkg::CFG_SATURATION:    saturation_q <= cfg_data[7:0];
				ghw_pkg::CFG_BRIGHTNESS:    brightness_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	ghw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ctrl   (ctrl)
	);

	assign busy = ctrl.busy;
	assign accept = start && ctrl.accept_ok;

	// index check against both the live glyph count and the memory depth
	assign idx_wide = {5'b0, item.glyph_index};
	assign err_in = ({1'b0, item.glyph_index} >= glyph_count_q)
		|| (32'(item.glyph_index) >= 32'(MAX_GLYPHS));

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= item.func;
			err_q <= err_in;
			idx_q <= item.glyph_index;
			dt_q <= item.delta_time;
		end
	end

	assign idx_q_wide = {5'b0, idx_q};

	ghw_phase_ram #(
		.DEPTH (MAX_GLYPHS),
		.AW    (AW)
	) u_phase_ram (
		.clk     (clk),
		.wr_en   (ctrl.phase_wr && !err_q),
		.wr_addr (idx_q_wide[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (accept && !err_in),
		.rd_addr (idx_wide[AW-1:0]),
		.rd_data (rd_data)
	);

	// Lookup: phase to hue sector and fraction (phase * 6 as shift-add),
	// phase increment dt/10 rounded half up, and the seed value.
	always_comb begin
		ph_clamp = (rd_data > ghw_pkg::PHASE_ONE) ? ghw_pkg::PHASE_ONE : rd_data;
		h6 = ({2'b0, ph_clamp} << 2) + ({2'b0, ph_clamp} << 1);
		// hue of exactly 360 degrees folds back to sector zero
		if (h6[18:16] >= 3'd6) begin
			sector = ghw_pkg::HUE_RY;
		end else begin
			sector = ghw_pkg::hue_sector_t'(h6[18:16]);
		end
		dt_round = {1'b0, dt_q} + ghw_pkg::DT_ROUND;
		inc_prod = {21'b0, dt_round} * {21'b0, ghw_pkg::RECIP_10};
		seed_prod = {16'b0, idx_q} * {8'b0, phase_spacing_q};
		seed = (seed_prod > {7'b0, ghw_pkg::PHASE_ONE})
			? ghw_pkg::PHASE_ONE : seed_prod[16:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_s2) begin
			ph_s2 <= ph_clamp;
			frac_s2 <= h6[15:0];
			sector_s2 <= sector;
			inc_s2 <= inc_prod[40:24];
			seed_s2 <= seed;
		end
	end

	// Mix: advance the phase (past 1.0 it restarts at zero) and write it back, or write the seed for a seed item
	assign adv_sum = {1'b0, ph_s2} + {1'b0, inc_s2};
	assign adv_phase = (adv_sum > {1'b0, ghw_pkg::PHASE_ONE}) ? '0 : adv_sum[16:0];
	assign wr_data = (func_q == ghw_pkg::FUNC_APPLY) ? adv_phase : seed_s2;

	assign x_q_lane = {1'b0, frac_s2};
	assign x_t_lane = ghw_pkg::PHASE_ONE - {1'b0, frac_s2};

	// p, q and t lanes; v is the brightness itself
	ghw_hsv_chan u_chan_p (
		.clk  (clk),
		.x    (ghw_pkg::PHASE_ONE),
		.sat  (saturation_q),
		.val  (brightness_q),
		.chan (chan_p)
	);

	ghw_hsv_chan u_chan_q (
		.clk  (clk),
		.x    (x_q_lane),
		.sat  (saturation_q),
		.val  (brightness_q),
		.chan (chan_q)
	);

	ghw_hsv_chan u_chan_t (
		.clk  (clk),
		.x    (x_t_lane),
		.sat  (saturation_q),
		.val  (brightness_q),
		.chan (chan_t)
	);

	assign chan_v = brightness_q;

	// sector to channel routing
	always_comb begin
		case (sector_s2)
			ghw_pkg::HUE_RY: begin red_c = chan_v; green_c = chan_t; blue_c = chan_p; end
			ghw_pkg::HUE_YG: begin red_c = chan_q; green_c = chan_v; blue_c = chan_p; end
			ghw_pkg::HUE_GC: begin red_c = chan_p; green_c = chan_v; blue_c = chan_t; end
			ghw_pkg::HUE_CB: begin red_c = chan_p; green_c = chan_q; blue_c = chan_v; end
			ghw_pkg::HUE_BM: begin red_c = chan_t; green_c = chan_p; blue_c = chan_v; end
			default:         begin red_c = chan_v; green_c = chan_p; blue_c = chan_q; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.result_ld;
		end
	end

	// seeds and rejected indices report black
	always_ff @(posedge clk) begin
		if (ctrl.result_ld) begin
			if (err_q || (func_q == ghw_pkg::FUNC_SEED)) begin
				result_q.red <= '0;
				result_q.green <= '0;
				result_q.blue <= '0;
			end else begin
				result_q.red <= red_c;
				result_q.green <= green_c;
				result_q.blue <= blue_c;
			end
			result_q.index_error <= err_q;
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

FILE: rtl/core/ghw_checker.sv
// Port-level checker for the hue wave color block, bound to the top level.
module ghw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input ghw_pkg::result_t result
);

	// an accepted transaction holds busy through the lookup, mix and scale steps, then frees the port
	a_busy_window: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 busy ##1 busy ##1 !busy)
		else $error("busy window wrong after accept");

	// every accepted transaction reports a result
	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result strobe missing");

	// results are one-cycle strobes
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// a rejected index reports black
	a_err_black: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.index_error) |->
		(result.red == 8'd0 && result.green == 8'd0 && result.blue == 8'd0))
		else $error("error result carries color");

endmodule

bind per_glyph_hue_wave_color ghw_checker u_ghw_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

FILE: tb/per_glyph_hue_wave_color_test.sv
// Self-checking testbench for the per-glyph hue wave color block.
module per_glyph_hue_wave_color_test;

	localparam int GLYPHS = 256;
	// cycles with no transaction of any kind before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int RANDOM_PHASES = 8;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	ghw_pkg::item_t    glyph_item;
	logic              done;
	ghw_pkg::result_t  glyph_color;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;

	per_glyph_hue_wave_color #(
		.MAX_GLYPHS(GLYPHS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(glyph_item),
		.done(done),
		.result(glyph_color),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// ------------------------------------------------------------------
	// Shadow of the block: register copies and per-glyph phase (Q1.16)
	// ------------------------------------------------------------------
	logic [8:0]  sh_count;
	logic [15:0] sh_spacing;
	logic [7:0]  sh_sat;
	logic [7:0]  sh_bri;
	logic [16:0] sh_phase [GLYPHS];
	// glyphs seeded since reset; only these may be applied
	bit          seeded [GLYPHS];

	ghw_pkg::result_t pending_colors [$];

	// directed rows may carry a color typed in by hand
	bit               pin_on;
	ghw_pkg::result_t pin_val;

	int fail_count;
	int n_items, n_seeds, n_applies, n_flagged, n_writes, n_results;

	// V * (1 - S/255 * x/65536), rounded half up
	function automatic logic [7:0] hsv_level(int unsigned x);
		longint unsigned den;
		longint unsigned num;
		den = 64'd255 * 64'd65536;
		num = longint'(sh_bri) * (den - longint'(sh_sat) * longint'(x));
		return 8'((num + den / 2) / den);
	endfunction

	// Color for one transaction; updates the shadow phase as the block does.
	function automatic ghw_pkg::result_t hue_wave_step(ghw_pkg::item_t it);
		ghw_pkg::result_t res;
		int unsigned      seed, ph, h6, frac, nxt, sec;
		logic [7:0]       cv, cp, cq, ct;
		res = '0;
		if (int'(it.glyph_index) >= int'(sh_count) || int'(it.glyph_index) >= GLYPHS) begin
			res.index_error = 1'b1;
			n_flagged++;
			return res;
		end
		if (it.func == ghw_pkg::FUNC_SEED) begin
			seed = int'(it.glyph_index) * int'(sh_spacing);
			if (seed > ghw_pkg::PHASE_ONE)
				seed = ghw_pkg::PHASE_ONE;
			sh_phase[it.glyph_index] = 17'(seed);
			seeded[it.glyph_index] = 1'b1;
			n_seeds++;
			return res;
		end
		n_applies++;
		ph = sh_phase[it.glyph_index];
		if (ph > ghw_pkg::PHASE_ONE)
			ph = ghw_pkg::PHASE_ONE;
		h6 = ph * 6;
		sec = h6 >> 16;
		frac = h6 & 32'hFFFF;
		// hue of exactly 360 degrees folds back to red
		if (sec >= 6)
			sec = 0;
		cv = hsv_level(0);
		cp = hsv_level(ghw_pkg::PHASE_ONE);
		cq = hsv_level(frac);
		ct = hsv_level(ghw_pkg::PHASE_ONE - frac);
		case (ghw_pkg::hue_sector_t'(sec[2:0]))
			ghw_pkg::HUE_RY: begin res.red = cv; res.green = ct; res.blue = cp; end
			ghw_pkg::HUE_YG: begin res.red = cq; res.green = cv; res.blue = cp; end
			ghw_pkg::HUE_GC: begin res.red = cp; res.green = cv; res.blue = ct; end
			ghw_pkg::HUE_CB: begin res.red = cp; res.green = cq; res.blue = cv; end
			ghw_pkg::HUE_BM: begin res.red = ct; res.green = cp; res.blue = cv; end
			default: begin res.red = cv; res.green = cp; res.blue = cq; end
		endcase
		// advance by 0.1 * dt; overshooting one resets instead of wrapping
		nxt = ph + (int'(it.delta_time) + 5) / 10;
		if (nxt > ghw_pkg::PHASE_ONE)
			nxt = 0;
		sh_phase[it.glyph_index] = 17'(nxt);
		return res;
	endfunction

	task automatic field_miss(string name, logic [7:0] want, logic [7:0] got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		fail_count++;
	endtask

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Monitor: checks results first, then records what was accepted at
	// this edge. A result at an edge always belongs to an earlier item.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		ghw_pkg::result_t want;
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (pending_colors.size() == 0) begin
					$display("%0t: result with nothing outstanding, got %h", $time,
						glyph_color);
					fail_count++;
				end else begin
					want = pending_colors.pop_front();
					if (glyph_color.red !== want.red)
						field_miss("red", want.red, glyph_color.red);
					if (glyph_color.green !== want.green)
						field_miss("green", want.green, glyph_color.green);
					if (glyph_color.blue !== want.blue)
						field_miss("blue", want.blue, glyph_color.blue);
					if (glyph_color.index_error !== want.index_error)
						field_miss("index_error", 8'(want.index_error),
							8'(glyph_color.index_error));
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_writes++;
				case (cfg_index)
					ghw_pkg::CFG_GLYPH_COUNT: sh_count = cfg_data[8:0];
					ghw_pkg::CFG_PHASE_SPACING: sh_spacing = cfg_data;
					ghw_pkg::CFG_SATURATION: sh_sat = cfg_data[7:0];
					ghw_pkg::CFG_BRIGHTNESS: sh_bri = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				n_items++;
				want = hue_wave_step(glyph_item);
				// a hand-typed color overrides the prediction for that row
				if (pin_on)
					want = pin_val;
				pending_colors.push_back(want);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: any transaction resets the idle count
	// ------------------------------------------------------------------
	int idle_cycles;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
				idle_cycles, pending_colors.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Driver side. Inputs change on the falling edge only.
	// ------------------------------------------------------------------

	// Present one item (caller is already at a falling edge) and hold it
	// until the block takes it.
	task automatic offer(ghw_pkg::item_t it, bit pinned, ghw_pkg::result_t want);
		start <= 1'b1;
		glyph_item <= it;
		pin_on <= pinned;
		pin_val <= want;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Stop sending and wait until every outstanding color has come back.
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		// each item yields a result, so a short settle covers the pipeline
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Directed rows: either a register write or an item, the latter with an
	// optional color typed in by hand.
	typedef struct {
		bit               is_cfg;
		logic [1:0]       reg_idx;
		logic [15:0]      reg_data;
		ghw_pkg::item_t   stim;
		bit               pinned;
		ghw_pkg::result_t want;
	} plan_row_t;

	plan_row_t plan [$];

	function automatic void add_cfg(logic [1:0] idx, logic [15:0] data);
		plan_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		plan.push_back(row);
	endfunction

	function automatic void add_item(logic fn, logic [7:0] gi, logic [19:0] dt, bit pinned,
			ghw_pkg::result_t want);
		plan_row_t row;
		row = '{default: '0};
		row.stim.func = fn;
		row.stim.glyph_index = gi;
		row.stim.delta_time = dt;
		row.pinned = pinned;
		row.want = want;
		plan.push_back(row);
	endfunction

	initial begin
		ghw_pkg::result_t zero_c, red_c, white_c, flag_c, half_red_c;
		ghw_pkg::item_t   pick;
		int               gap, lim, pool, sel;
		bit               gappy;
		logic [8:0]       cnt;
		logic [15:0]      data;

		zero_c = '0;
		red_c = {8'd255, 8'd0, 8'd0, 1'b0};
		white_c = {8'd255, 8'd255, 8'd255, 1'b0};
		flag_c = {8'd0, 8'd0, 8'd0, 1'b1};
		half_red_c = {8'd128, 8'd0, 8'd0, 1'b0};

		// every input known from time zero
		arst_n = 1'b0;
		start = 1'b0;
		glyph_item = '0;
		cfg_valid = 1'b0;
		cfg_index = ghw_pkg::CFG_GLYPH_COUNT;
		cfg_data = '0;
		pin_on = 1'b0;
		pin_val = '0;
		fail_count = 0;
		idle_cycles = 0;
		sh_count = 9'd256;
		sh_spacing = 16'd256;
		sh_sat = 8'd255;
		sh_bri = 8'd255;
		foreach (seeded[i]) begin
			seeded[i] = 1'b0;
			sh_phase[i] = '0;
		end

		// ---- directed part, starting from the reset register values ----
		add_item(ghw_pkg::FUNC_SEED, 8'd0, 20'hFFFFF, 1, zero_c);
		add_item(ghw_pkg::FUNC_APPLY, 8'd0, 20'd0, 1, red_c); // phase 0 is pure red
		add_item(ghw_pkg::FUNC_SEED, 8'd255, 20'd0, 1, zero_c);
		// magenta side, then overshoot
		add_item(ghw_pkg::FUNC_APPLY, 8'd255, 20'hFFFFF, 0, zero_c);
		// overshoot reset phase to 0
		add_item(ghw_pkg::FUNC_APPLY, 8'd255, 20'd0, 1, red_c);
		add_cfg(ghw_pkg::CFG_PHASE_SPACING, 16'hFFFF);
		add_item(ghw_pkg::FUNC_SEED, 8'd1, 20'd0, 1, zero_c);
		add_item(ghw_pkg::FUNC_SEED, 8'd2, 20'd0, 1, zero_c); // product clamps to one
		add_item(ghw_pkg::FUNC_APPLY, 8'd2, 20'd0, 1, red_c); // hue 360 folds to red
		add_item(ghw_pkg::FUNC_APPLY, 8'd1, 20'd10, 0, zero_c); // lands exactly on one
		add_item(ghw_pkg::FUNC_APPLY, 8'd1, 20'd15, 1, red_c); // exact one is kept
		add_item(ghw_pkg::FUNC_APPLY, 8'd1, 20'd14, 1, red_c);
		add_cfg(ghw_pkg::CFG_GLYPH_COUNT, 16'd0); // everything flagged
		add_item(ghw_pkg::FUNC_SEED, 8'd0, 20'd0, 1, flag_c);
		add_item(ghw_pkg::FUNC_APPLY, 8'd2, 20'd77, 1, flag_c);
		add_cfg(ghw_pkg::CFG_GLYPH_COUNT, 16'hFFFF); // count 511, above the table
		add_item(ghw_pkg::FUNC_SEED, 8'd255, 20'd0, 1, zero_c);
		add_cfg(ghw_pkg::CFG_GLYPH_COUNT, 16'd200);
		add_item(ghw_pkg::FUNC_SEED, 8'd200, 20'd0, 1, flag_c);
		add_item(ghw_pkg::FUNC_SEED, 8'd199, 20'd0, 1, zero_c);
		add_cfg(ghw_pkg::CFG_SATURATION, 16'd0); // gray: all channels at V
		add_item(ghw_pkg::FUNC_APPLY, 8'd1, 20'd0, 1, white_c);
		add_cfg(ghw_pkg::CFG_BRIGHTNESS, 16'd0);
		add_item(ghw_pkg::FUNC_APPLY, 8'd0, 20'd0, 1, zero_c);
		add_cfg(ghw_pkg::CFG_BRIGHTNESS, 16'd128);
		add_cfg(ghw_pkg::CFG_SATURATION, 16'd255);
		add_item(ghw_pkg::FUNC_APPLY, 8'd0, 20'd0, 1, half_red_c);
		add_item(ghw_pkg::FUNC_APPLY, 8'd255, 20'd12345, 0, zero_c);
		add_cfg(ghw_pkg::CFG_GLYPH_COUNT, 16'd1);
		add_item(ghw_pkg::FUNC_APPLY, 8'd1, 20'd0, 1, flag_c);
		add_item(ghw_pkg::FUNC_APPLY, 8'd0, 20'd3, 0, zero_c);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				cfg_write(plan[i].reg_idx, plan[i].reg_data);
			end else begin
				@(negedge clk);
				offer(plan[i].stim, plan[i].pinned, plan[i].want);
			end
		end

		// ---- random part: phases of new register settings ----
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			// registers change only with the block idle
			drain();

			sel = $urandom_range(0, 15);
			case (sel)
				0: cnt = 9'd0;
				1: cnt = 9'd1;
				2, 3: cnt = 9'd256;
				4: cnt = 9'd511;
				5: cnt = 9'($urandom_range(257, 510));
				default: cnt = 9'($urandom_range(2, 255));
			endcase
			// junk in the unused upper bits must be ignored
			data = 16'($urandom);
			data[8:0] = cnt;
			cfg_write(ghw_pkg::CFG_GLYPH_COUNT, data);

			sel = $urandom_range(0, 3);
			case (sel)
				0: data = 16'd0;
				1: data = 16'hFFFF;
				2: data = 16'($urandom_range(1, 1024));
				default: data = 16'($urandom);
			endcase
			cfg_write(ghw_pkg::CFG_PHASE_SPACING, data);

			for (int r = 0; r < 2; r++) begin
				data = 16'($urandom);
				sel = $urandom_range(0, 3);
				case (sel)
					0: data[7:0] = 8'd0;
					1: data[7:0] = 8'd255;
					default: data[7:0] = 8'($urandom_range(1, 254));
				endcase
				cfg_write(r == 0 ? ghw_pkg::CFG_SATURATION
					: ghw_pkg::CFG_BRIGHTNESS, data);
			end

			lim = (int'(cnt) > GLYPHS) ? GLYPHS : int'(cnt);
			// a small working set gives many applies per glyph, so hues walk
			// through every sector and past the reset point
			if (lim == 0)
				pool = 1;
			else if ($urandom_range(0, 1) == 0)
				pool = $urandom_range(1, lim);
			else
				pool = (lim < 8) ? lim : 8;
			gappy = ($urandom_range(0, 2) != 0);

			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// now and then hold off until the block has caught up
				if ($urandom_range(0, 49) == 0)
					drain();
				@(negedge clk);
				if (gappy) begin
					sel = $urandom_range(0, 99);
					if (sel < 70)
						gap = 0;
					else if (sel < 93)
						gap = $urandom_range(1, 3);
					else
						gap = $urandom_range(8, 40);
					if (gap > 0) begin
						start <= 1'b0;
						repeat (gap) @(negedge clk);
					end
				end

				if (lim == 0 || $urandom_range(0, 9) == 0)
					pick.glyph_index = 8'($urandom_range(0, 255));
				else
					pick.glyph_index = 8'($urandom_range(0, pool - 1));
				// never apply to a glyph whose phase was never written
				if (seeded[pick.glyph_index] && $urandom_range(0, 4) != 0)
					pick.func = ghw_pkg::FUNC_APPLY;
				else
					pick.func = ghw_pkg::FUNC_SEED;
				sel = $urandom_range(0, 9);
				if (sel < 3)
					pick.delta_time = 20'($urandom_range(0, 60));
				else if (sel < 7)
					pick.delta_time = 20'($urandom_range(0, 250000));
				else if (sel < 9)
					pick.delta_time = 20'($urandom);
				else
					pick.delta_time = ($urandom_range(0, 1) == 0) ? 20'd0 : 20'hFFFFF;
				offer(pick, 1'b0, zero_c);
			end
		end

		// ---- wind down ----
		drain();
		repeat (10) @(posedge clk);

		$display("Covered %0d items: %0d seeds, %0d applies, %0d flagged indexes",
			n_items, n_seeds, n_applies, n_flagged);
		$display("%0d colors checked over %0d register writes", n_results, n_writes);
		if (fail_count == 0 && pending_colors.size() == 0) begin
			$display("All tests passed");
		end else begin
			if (pending_colors.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_colors.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
